FILE: rtl/eca_pkg.sv
// Shared constants and types for the event cluster assigner.
// Used by the cluster memory, the centroid divider and the top level; no dependencies.
package eca_pkg;

   // Sizing of the cluster table and its fields.
   localparam int MAX_CLUSTERS  = 16;
   localparam int COORD_BITS    = 10;
   localparam int COUNT_BITS    = 16;
   localparam int TIME_BITS     = 63;
   localparam int WINDOW_BITS   = 32;
   localparam int LIMIT_BITS    = 10;
   localparam int SUM_BITS      = COORD_BITS + COUNT_BITS;
   localparam int IDX_BITS      = $clog2(MAX_CLUSTERS);
   localparam int USED_BITS     = $clog2(MAX_CLUSTERS + 1);
   localparam int SQ_BITS       = (2 * COORD_BITS + 1 > 2 * LIMIT_BITS + 2) ?
                                  2 * COORD_BITS + 1 : 2 * LIMIT_BITS + 2;

   // Width of the divider's step counter: one step per quotient bit.
   localparam int DIV_STEP_BITS = $clog2(COORD_BITS);

   // Configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = WINDOW_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TIME_WINDOW    = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_DISTANCE_LIMIT = CSR_INDEX_BITS'(1);

   // Reset values of the configuration registers.
   localparam logic [WINDOW_BITS-1:0] TIME_WINDOW_RESET    = WINDOW_BITS'(50);
   localparam logic [LIMIT_BITS-1:0]  DISTANCE_LIMIT_RESET = LIMIT_BITS'(5);

   // Saturation point of the member count.
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // One cluster as it is held in the memory.
   typedef struct packed {
      logic [TIME_BITS-1:0]  last_time;
      logic [SUM_BITS-1:0]   sum_x;
      logic [SUM_BITS-1:0]   sum_y;
      logic [COUNT_BITS-1:0] member_count;
      logic [COORD_BITS-1:0] centre_col;
      logic [COORD_BITS-1:0] centre_row;
   } entry_type;

   // Write request into the cluster memory.
   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] addr;
      entry_type           data;
   } ram_wr_type;

   // Request to the centroid divider.
   typedef struct packed {
      logic                  start;
      logic [SUM_BITS-1:0]   sum_x;
      logic [SUM_BITS-1:0]   sum_y;
      logic [COUNT_BITS-1:0] count;
   } div_req_type;

   // Answer of the centroid divider.
   typedef struct packed {
      logic                  done;
      logic [COORD_BITS-1:0] quot_x;
      logic [COORD_BITS-1:0] quot_y;
   } div_rsp_type;

endpackage

FILE: rtl/eca_cluster_ram.sv
// Cluster table memory: one write port and one registered read port.
// Depends on eca_pkg for the entry layout and the table depth.
module eca_cluster_ram (
   input  logic                           clock,
   input  eca_pkg::ram_wr_type            wr,
   input  logic                           rd_en,
   input  logic [eca_pkg::IDX_BITS-1:0]   rd_addr,
   output eca_pkg::entry_type             rd_data
);
   import eca_pkg::*;

   entry_type mem_ff [MAX_CLUSTERS];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Registered read port: the data for an address is shown in the cycle after the read; it holds between reads.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/eca_divider.sv
// Restoring divider for the cluster center, one quotient bit per cycle on both axes.
// Depends on eca_pkg. A sum never exceeds count times the largest coordinate,
// so the quotient always fits in COORD_BITS and only that many steps are needed.
module eca_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  eca_pkg::div_req_type req,
   output eca_pkg::div_rsp_type rsp
);
   import eca_pkg::*;

   logic                     busy_ff;
   logic                     done_ff;
   logic [DIV_STEP_BITS-1:0] cnt_ff;
   logic [SUM_BITS-1:0]      rem_x_ff;
   logic [SUM_BITS-1:0]      rem_y_ff;
   logic [SUM_BITS-1:0]      dsh_ff;
   logic [COORD_BITS-1:0]    qx_ff;
   logic [COORD_BITS-1:0]    qy_ff;

   logic ge_x;
   logic ge_y;

   // Trial subtraction of the shifted divisor on each axis.
   assign ge_x = (rem_x_ff >= dsh_ff);
   assign ge_y = (rem_y_ff >= dsh_ff);

   // Control: step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_STEP_BITS'(COORD_BITS - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: partial remainders, shifted divisor and quotients.
   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_x_ff <= req.sum_x;
         rem_y_ff <= req.sum_y;
         dsh_ff   <= SUM_BITS'(req.count) << (COORD_BITS - 1);
         qx_ff    <= '0;
         qy_ff    <= '0;
      end else if (busy_ff) begin
         rem_x_ff <= ge_x ? rem_x_ff - dsh_ff : rem_x_ff;
         rem_y_ff <= ge_y ? rem_y_ff - dsh_ff : rem_y_ff;
         dsh_ff   <= dsh_ff >> 1;
         qx_ff    <= {qx_ff[COORD_BITS-2:0], ge_x};
         qy_ff    <= {qy_ff[COORD_BITS-2:0], ge_y};
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.quot_x = qx_ff;
   assign rsp.quot_y = qy_ff;

endmodule

FILE: rtl/event_cluster_assigner.sv
// Event cluster assigner: a clear transfer empties the table and shows its result in the
// next cycle; an event is scanned against the clusters in use and then opens a cluster or is
// dropped, or updates the matching cluster, with a center divide unless it is at its count limit.
// The next item is taken in the cycle its predecessor's result is shown; the
// scan issues one memory read per cycle and the center divide takes one bit per cycle.
// Synchronous reset empties the table and restores the register defaults; results cannot be stalled.
module event_cluster_assigner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_cmd,
   input  logic [eca_pkg::COORD_BITS-1:0]      req_event_x,
   input  logic [eca_pkg::COORD_BITS-1:0]      req_event_y,
   input  logic [eca_pkg::TIME_BITS-1:0]       req_event_time,
   output logic                                rsp_valid,
   output logic [eca_pkg::IDX_BITS-1:0]        rsp_cluster_index,
   output logic                                rsp_created,
   output logic                                rsp_dropped,
   output logic [eca_pkg::COORD_BITS-1:0]      rsp_centre_x,
   output logic [eca_pkg::COORD_BITS-1:0]      rsp_centre_y,
   output logic [eca_pkg::USED_BITS-1:0]       rsp_clusters_in_use,
   input  logic                                csr_write,
   input  logic [eca_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [eca_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import eca_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_FETCH  = 5'b00100,
      ST_LOAD   = 5'b01000,
      ST_DIVIDE = 5'b10000
   } state_type;

   typedef struct packed {
      logic                  valid;
      logic [IDX_BITS-1:0]   cluster_index;
      logic                  created;
      logic                  dropped;
      logic [COORD_BITS-1:0] centre_x;
      logic [COORD_BITS-1:0] centre_y;
      logic [USED_BITS-1:0]  clusters_in_use;
   } rsp_type;

   state_type             state_ff, state_in;
   logic [USED_BITS-1:0]  used_ff, used_in;
   logic [USED_BITS-1:0]  scan_ptr_ff, scan_ptr_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   entry_type             upd_ff, upd_in;
   rsp_type               rsp_ff, rsp_in;

   logic [COORD_BITS-1:0] ev_x_ff;
   logic [COORD_BITS-1:0] ev_y_ff;
   logic [TIME_BITS-1:0]  ev_t_ff;

   logic [WINDOW_BITS-1:0] window_ff;
   logic [LIMIT_BITS-1:0]  limit_ff;
   logic [SQ_BITS-1:0]     limsq_ff;

   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [IDX_BITS-1:0]     s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [COORD_BITS-1:0]   s2_dx_ff, s2_dy_ff;
   logic                    s2_tok_ff, s3_tok_ff;
   logic [2*COORD_BITS-1:0] s3_sqx_ff, s3_sqy_ff;

   logic                    accept;
   logic                    issue;
   logic                    keep;
   logic                    hit;
   logic                    rd_en;
   logic [IDX_BITS-1:0]     rd_addr;
   entry_type               rd_data;
   ram_wr_type              wr;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   logic [COORD_BITS-1:0]   s1_dx, s1_dy;
   logic [TIME_BITS:0]      s1_gap;
   logic                    s1_tok;
   logic [2*COORD_BITS-1:0] s2_sqx, s2_sqy;
   logic [SQ_BITS-1:0]      s3_dist;
   logic [LIMIT_BITS:0]     lim;
   logic [2*LIMIT_BITS+1:0] lim_sq;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Cluster memory and center divider.
   eca_cluster_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   eca_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Configuration registers; the squared distance bound follows the limit.
   assign lim    = (LIMIT_BITS + 1)'(limit_ff) + 1'b1;
   assign lim_sq = lim * lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= TIME_WINDOW_RESET;
         limit_ff  <= DISTANCE_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_TIME_WINDOW: begin
               window_ff <= csr_wdata[WINDOW_BITS-1:0];
            end
            REG_DISTANCE_LIMIT: begin
               limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      limsq_ff <= SQ_BITS'(lim_sq);
   end

   // Event capture on transfer.
   always_ff @(posedge clock) begin
      if (accept) begin
         ev_x_ff <= req_event_x;
         ev_y_ff <= req_event_y;
         ev_t_ff <= req_event_time;
      end
   end

   // Scan stage 1: distances per axis and the signed time test.
   assign s1_dx  = (ev_x_ff >= rd_data.centre_col) ? ev_x_ff - rd_data.centre_col
                                                   : rd_data.centre_col - ev_x_ff;
   assign s1_dy  = (ev_y_ff >= rd_data.centre_row) ? ev_y_ff - rd_data.centre_row
                                                   : rd_data.centre_row - ev_y_ff;
   assign s1_gap = {1'b0, ev_t_ff} - {1'b0, rd_data.last_time};
   assign s1_tok = s1_gap[TIME_BITS] ||
                   (s1_gap[TIME_BITS-1:0] <= TIME_BITS'(window_ff));

   // Scan stage 2: squares. Stage 3: compare against the bound.
   assign s2_sqx  = s2_dx_ff * s2_dx_ff;
   assign s2_sqy  = s2_dy_ff * s2_dy_ff;
   assign s3_dist = SQ_BITS'(s3_sqx_ff) + SQ_BITS'(s3_sqy_ff);
   assign hit     = (state_ff == ST_SCAN) && s3_valid_ff && s3_tok_ff &&
                    (s3_dist < limsq_ff);

   // The pipeline is flushed once a match is found or the scan ends.
   assign keep = (state_ff == ST_SCAN) && !hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff && keep;
         s3_valid_ff <= s2_valid_ff && keep;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= scan_ptr_ff[IDX_BITS-1:0];
      s2_idx_ff <= s1_idx_ff;
      s2_dx_ff  <= s1_dx;
      s2_dy_ff  <= s1_dy;
      s2_tok_ff <= s1_tok;
      s3_idx_ff <= s2_idx_ff;
      s3_sqx_ff <= s2_sqx;
      s3_sqy_ff <= s2_sqy;
      s3_tok_ff <= s2_tok_ff;
   end

   // Sequencer: clear; or scan, then open a cluster, drop, or fetch the match, update, write back.
   // Reads and writes of one item never overlap, so no forwarding is needed.
   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      scan_ptr_in = scan_ptr_ff;
      hit_idx_in  = hit_idx_ff;
      upd_in      = upd_ff;
      rsp_in      = '0;
      issue       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = scan_ptr_ff[IDX_BITS-1:0];
      wr          = '0;
      div_req     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd) begin
                  used_in      = '0;
                  rsp_in.valid = 1'b1;
               end else begin
                  scan_ptr_in = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               hit_idx_in = s3_idx_ff;
               state_in   = ST_FETCH;
            end else if (scan_ptr_ff < used_ff) begin
               issue       = 1'b1;
               rd_en       = 1'b1;
               scan_ptr_in = scan_ptr_ff + 1'b1;
            end else if (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff) begin
               // No cluster matched: open a new one or drop the event.
               rsp_in.valid = 1'b1;
               if (used_ff < USED_BITS'(MAX_CLUSTERS)) begin
                  wr.en                     = 1'b1;
                  wr.addr                   = used_ff[IDX_BITS-1:0];
                  wr.data.last_time         = ev_t_ff;
                  wr.data.sum_x             = SUM_BITS'(ev_x_ff);
                  wr.data.sum_y             = SUM_BITS'(ev_y_ff);
                  wr.data.member_count      = COUNT_BITS'(1);
                  wr.data.centre_col        = ev_x_ff;
                  wr.data.centre_row        = ev_y_ff;
                  used_in                   = used_ff + 1'b1;
                  rsp_in.cluster_index      = used_ff[IDX_BITS-1:0];
                  rsp_in.created            = 1'b1;
                  rsp_in.centre_x           = ev_x_ff;
                  rsp_in.centre_y           = ev_y_ff;
                  rsp_in.clusters_in_use    = used_ff + 1'b1;
               end else begin
                  rsp_in.dropped         = 1'b1;
                  rsp_in.clusters_in_use = used_ff;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            rd_addr  = hit_idx_ff;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            upd_in           = rd_data;
            upd_in.last_time = ev_t_ff;
            if (rd_data.member_count == COUNT_MAX) begin
               // Saturated cluster: only the timestamp moves.
               wr.en                  = 1'b1;
               wr.addr                = hit_idx_ff;
               wr.data                = upd_in;
               rsp_in.valid           = 1'b1;
               rsp_in.cluster_index   = hit_idx_ff;
               rsp_in.centre_x        = rd_data.centre_col;
               rsp_in.centre_y        = rd_data.centre_row;
               rsp_in.clusters_in_use = used_ff;
               state_in               = ST_IDLE;
            end else begin
               upd_in.sum_x        = rd_data.sum_x + SUM_BITS'(ev_x_ff);
               upd_in.sum_y        = rd_data.sum_y + SUM_BITS'(ev_y_ff);
               upd_in.member_count = rd_data.member_count + 1'b1;
               div_req.start       = 1'b1;
               div_req.sum_x       = upd_in.sum_x;
               div_req.sum_y       = upd_in.sum_y;
               div_req.count       = upd_in.member_count;
               state_in            = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               wr.en                  = 1'b1;
               wr.addr                = hit_idx_ff;
               wr.data                = upd_ff;
               wr.data.centre_col     = div_rsp.quot_x;
               wr.data.centre_row     = div_rsp.quot_y;
               rsp_in.valid           = 1'b1;
               rsp_in.cluster_index   = hit_idx_ff;
               rsp_in.centre_x        = div_rsp.quot_x;
               rsp_in.centre_y        = div_rsp.quot_y;
               rsp_in.clusters_in_use = used_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         rsp_ff   <= rsp_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      hit_idx_ff  <= hit_idx_in;
      upd_ff      <= upd_in;
   end

   assign rsp_valid           = rsp_ff.valid;
   assign rsp_cluster_index   = rsp_ff.cluster_index;
   assign rsp_created         = rsp_ff.created;
   assign rsp_dropped         = rsp_ff.dropped;
   assign rsp_centre_x        = rsp_ff.centre_x;
   assign rsp_centre_y        = rsp_ff.centre_y;
   assign rsp_clusters_in_use = rsp_ff.clusters_in_use;

   // The sequencer never reads and writes the table in the same cycle.
   assert property (@(posedge clock) disable iff (reset) !(wr.en && rd_en))
      else $error("cluster table read and write in the same cycle");

   // The table never reports more clusters than it holds.
   assert property (@(posedge clock) disable iff (reset)
                    used_ff <= USED_BITS'(MAX_CLUSTERS))
      else $error("cluster count beyond table depth");

   // A clear transfer yields an empty-table result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
                    (accept && req_cmd) |=> (rsp_valid && rsp_clusters_in_use == '0))
      else $error("clear did not produce an empty result");

   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
                    div_rsp.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide state");

endmodule
